// ----- hdl/i2c_multi_message_sequencer_core_assert.svh -----
// assertion macros used by the sequencer checker
`ifndef I2C_MULTI_MESSAGE_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MULTI_MESSAGE_SEQUENCER_CORE_ASSERT_SVH

// clocked on clk_i, quiet while rst_ni is low
`define I2CMS_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define I2CMS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("check failed");

`endif

// ----- hdl/i2cms_pkg.sv -----
// shared types and constants of the i2c multi-message sequencer
package i2cms_pkg;

  localparam int unsigned MAX_MESSAGES_DEF = 8;

  typedef enum logic [1:0] {
    FUNC_LOAD     = 2'd0,
    FUNC_START    = 2'd1,
    FUNC_TX_READY = 2'd2,
    FUNC_RX_BYTE  = 2'd3
  } func_e;

  typedef struct packed {
    logic       nors;
    logic       rd;
    logic [7:0] length;
  } desc_t;

  typedef struct packed {
    func_e      func;
    logic [2:0] desc_index;
    logic [7:0] desc_length;
    logic       desc_read;
    logic       desc_nors;
    logic [6:0] slave_address;
    logic [3:0] msg_count;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       issue_start;
    logic       issue_stop;
    logic       transmit_mode;
    logic [6:0] address_out;
    logic       byte_valid;
    logic [2:0] msg_index;
    logic [7:0] byte_offset;
    logic [7:0] store_byte;
    logic       done_res;
  } out_item_t;

  typedef struct packed {
    desc_t first;
    desc_t next;
  } tbl_rd_t;

endpackage

// ----- hdl/i2cms_if.sv -----
// input and result channel interfaces of the sequencer
interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [2:0] desc_index;
  logic [7:0] desc_length;
  logic       desc_read;
  logic       desc_nors;
  logic [6:0] slave_address;
  logic [3:0] msg_count;
  logic [7:0] rx_byte;

  modport source (
    output valid, func, desc_index, desc_length, desc_read, desc_nors,
    output slave_address, msg_count, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, func, desc_index, desc_length, desc_read, desc_nors,
    input  slave_address, msg_count, rx_byte,
    output ready
  );
endinterface

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic       issue_start;
  logic       issue_stop;
  logic       transmit_mode;
  logic [6:0] address_out;
  logic       byte_valid;
  logic [2:0] msg_index;
  logic [7:0] byte_offset;
  logic [7:0] store_byte;
  logic       done_res;

  modport source (
    output valid, issue_start, issue_stop, transmit_mode, address_out, byte_valid,
    output msg_index, byte_offset, store_byte, done_res,
    input  ready
  );
  modport sink (
    input  valid, issue_start, issue_stop, transmit_mode, address_out, byte_valid,
    input  msg_index, byte_offset, store_byte, done_res,
    output ready
  );
endinterface

// ----- hdl/i2cms_desc_tbl.sv -----
// descriptor memory with slot zero copy and next-descriptor prefetch
module i2cms_desc_tbl #(
  parameter  int unsigned MAX_MESSAGES = i2cms_pkg::MAX_MESSAGES_DEF,
  localparam int unsigned IdxW = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [IdxW-1:0]       wr_addr_i,
  input  i2cms_pkg::desc_t      wr_data_i,
  input  logic [IdxW-1:0]       rd_addr_i,
  input  logic                  rd_ok_i,
  output i2cms_pkg::tbl_rd_t    tbl_o
);

  i2cms_pkg::desc_t mem_q [MAX_MESSAGES];
  i2cms_pkg::desc_t first_q;
  i2cms_pkg::desc_t next_q;
  logic             next_ok_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (wr_en_i && (wr_addr_i == '0)) begin
      first_q <= wr_data_i;
    end
    // write to the slot being fetched wins over the stale entry
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      next_q <= wr_data_i;
    end else if (rd_ok_i) begin
      next_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_ok_q <= 1'b0;
    end else begin
      next_ok_q <= rd_ok_i;
    end
  end

  assign tbl_o.first = first_q;
  assign tbl_o.next  = next_ok_q ? next_q : '0;

endmodule

// ----- hdl/i2cms_seq.sv -----
// sequencer state and per-transaction command logic
module i2cms_seq #(
  parameter  int unsigned MAX_MESSAGES = i2cms_pkg::MAX_MESSAGES_DEF,
  localparam int unsigned IdxW = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  i2cms_pkg::in_item_t   item_i,
  input  i2cms_pkg::tbl_rd_t    tbl_i,
  output logic                  wr_en_o,
  output logic [IdxW-1:0]       wr_addr_o,
  output i2cms_pkg::desc_t      wr_data_o,
  output logic [IdxW-1:0]       rd_addr_o,
  output logic                  rd_ok_o,
  output i2cms_pkg::out_item_t  res_o
);

  logic [IdxW-1:0] ml_q, ml_d;
  logic [IdxW-1:0] cm_q, cm_d;
  logic [7:0]      bl_q, bl_d;
  logic [7:0]      co_q, co_d;
  logic            tx_q, tx_d;
  logic [6:0]      addr_q, addr_d;

  logic            start;
  logic            stop;
  logic            bvalid;
  logic            send;
  logic [IdxW-1:0] idx;
  logic [7:0]      off;
  logic [7:0]      stored;
  logic [7:0]      bl_dec;
  logic [8:0]      cnt;
  logic [IdxW:0]   nxt_ext;
  logic [31:0]     slot32;
  logic [31:0]     idx32;
  i2cms_pkg::desc_t nd;
  i2cms_pkg::desc_t d0;

  assign nd = tbl_i.next;
  assign d0 = tbl_i.first;

  always_comb begin
    ml_d   = ml_q;
    cm_d   = cm_q;
    bl_d   = bl_q;
    co_d   = co_q;
    tx_d   = tx_q;
    addr_d = addr_q;
    start  = 1'b0;
    stop   = 1'b0;
    bvalid = 1'b0;
    send   = 1'b1;
    idx    = '0;
    off    = 8'd0;
    stored = 8'd0;
    bl_dec = (bl_q != 8'd0) ? (bl_q - 8'd1) : 8'd0;
    cnt    = {5'd0, item_i.msg_count};
    if (cnt == 9'd0) begin
      cnt = 9'd1;
    end
    if (cnt > 9'(MAX_MESSAGES)) begin
      cnt = 9'(MAX_MESSAGES);
    end
    if (step_i) begin
      case (item_i.func)
        i2cms_pkg::FUNC_LOAD: begin
        end
        i2cms_pkg::FUNC_START: begin
          addr_d = item_i.slave_address;
          ml_d   = IdxW'(cnt - 9'd1);
          cm_d   = '0;
          co_d   = 8'd0;
          bl_d   = d0.length;
          start  = 1'b1;
          if (d0.rd) begin
            tx_d = 1'b0;
            stop = (ml_d == '0) && (bl_d == 8'd1);
          end else begin
            tx_d = 1'b1;
          end
        end
        i2cms_pkg::FUNC_TX_READY: begin
          if (bl_q == 8'd0) begin
            if (ml_q != '0) begin
              ml_d = ml_q - IdxW'(1);
              cm_d = cm_q + IdxW'(1);
              co_d = 8'd0;
              bl_d = nd.length;
              if (nd.rd) begin
                tx_d  = 1'b0;
                start = 1'b1;
                stop  = (ml_d == '0) && (bl_d == 8'd1);
                send  = 1'b0;
              end else if (!nd.nors) begin
                start = 1'b1;
                send  = 1'b0;
              end
            end else begin
              stop = 1'b1;
              send = 1'b0;
            end
          end
          if (send && (bl_d != 8'd0)) begin
            bvalid = 1'b1;
            idx    = cm_d;
            off    = co_d;
            co_d   = co_d + 8'd1;
            bl_d   = bl_d - 8'd1;
          end
        end
        i2cms_pkg::FUNC_RX_BYTE: begin
          bvalid = 1'b1;
          idx    = cm_q;
          off    = co_q;
          stored = item_i.rx_byte;
          co_d   = co_q + 8'd1;
          bl_d   = bl_dec;
          if (bl_dec == 8'd0) begin
            if (ml_q != '0) begin
              ml_d = ml_q - IdxW'(1);
              cm_d = cm_q + IdxW'(1);
              co_d = 8'd0;
              bl_d = nd.length;
              if (nd.rd) begin
                if (!nd.nors) begin
                  start = 1'b1;
                  stop  = (ml_d == '0) && (bl_d == 8'd1);
                end
              end else begin
                tx_d  = 1'b1;
                start = 1'b1;
              end
            end
          end else if ((ml_q == '0) && (bl_dec == 8'd1)) begin
            stop = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ml_q   <= '0;
      cm_q   <= '0;
      bl_q   <= 8'd0;
      co_q   <= 8'd0;
      tx_q   <= 1'b0;
      addr_q <= 7'd0;
    end else begin
      ml_q   <= ml_d;
      cm_q   <= cm_d;
      bl_q   <= bl_d;
      co_q   <= co_d;
      tx_q   <= tx_d;
      addr_q <= addr_d;
    end
  end

  // descriptor table access
  assign slot32    = 32'(item_i.desc_index);
  assign wr_en_o   = step_i && (item_i.func == i2cms_pkg::FUNC_LOAD) &&
                     (slot32 < 32'(MAX_MESSAGES));
  assign wr_addr_o = slot32[IdxW-1:0];
  assign wr_data_o = '{nors:   item_i.desc_nors,
                       rd:     item_i.desc_read,
                       length: item_i.desc_length};
  assign nxt_ext   = {1'b0, cm_d} + (IdxW+1)'(1);
  assign rd_ok_o   = nxt_ext < (IdxW+1)'(MAX_MESSAGES);
  assign rd_addr_o = nxt_ext[IdxW-1:0];

  assign idx32 = 32'(idx);

  assign res_o.issue_start   = start;
  assign res_o.issue_stop    = stop;
  assign res_o.transmit_mode = tx_d;
  assign res_o.address_out   = addr_d;
  assign res_o.byte_valid    = bvalid;
  assign res_o.msg_index     = idx32[2:0];
  assign res_o.byte_offset   = off;
  assign res_o.store_byte    = stored;
  assign res_o.done_res      = (bl_d == 8'd0) && (ml_d == '0);

endmodule

// ----- hdl/i2c_multi_message_sequencer_core.sv -----
// top level of the i2c multi-message sequencer
//
// in_i carries one transaction per command: load descriptor, start, transmit
// ready or byte received. out_o carries exactly one result per command, in
// order: start/stop requests, direction, address, and the message and byte
// offset of the data byte sent or stored, plus the done flag.
// A command is taken into an input register, worked through the sequencer
// logic and written to the result register. One command per cycle is
// sustained while results are taken; the descriptor memory keeps the next
// descriptor prefetched so a message change does not slow the flow.
// When the result register is full and out_o.ready is low, the input register
// holds one more command and in_i.ready then falls until the result is taken.
// Reset clears the counters, direction and address; the descriptor table is
// undefined until loaded and needs no clearing pass.
module i2c_multi_message_sequencer_core #(
  parameter int unsigned MAX_MESSAGES = i2cms_pkg::MAX_MESSAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  i2cms_in_if.sink           in_i,
  i2cms_out_if.source        out_o
);

  localparam int unsigned IdxW = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;

  logic                 in_vld_q;
  i2cms_pkg::in_item_t  in_item_q;
  logic                 out_vld_q;
  i2cms_pkg::out_item_t out_item_q;
  logic                 step;
  i2cms_pkg::out_item_t res;
  i2cms_pkg::tbl_rd_t   tbl;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  i2cms_pkg::desc_t     wr_data;
  logic [IdxW-1:0]      rd_addr;
  logic                 rd_ok;

  assign step       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q.func          <= i2cms_pkg::func_e'(in_i.func);
      in_item_q.desc_index    <= in_i.desc_index;
      in_item_q.desc_length   <= in_i.desc_length;
      in_item_q.desc_read     <= in_i.desc_read;
      in_item_q.desc_nors     <= in_i.desc_nors;
      in_item_q.slave_address <= in_i.slave_address;
      in_item_q.msg_count     <= in_i.msg_count;
      in_item_q.rx_byte       <= in_i.rx_byte;
    end
    if (step) begin
      out_item_q <= res;
    end
  end

  i2cms_desc_tbl #(
    .MAX_MESSAGES (MAX_MESSAGES)
  ) u_desc_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_ok_i   (rd_ok),
    .tbl_o     (tbl)
  );

  i2cms_seq #(
    .MAX_MESSAGES (MAX_MESSAGES)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_item_q),
    .tbl_i     (tbl),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_addr_o (rd_addr),
    .rd_ok_o   (rd_ok),
    .res_o     (res)
  );

  assign out_o.valid         = out_vld_q;
  assign out_o.issue_start   = out_item_q.issue_start;
  assign out_o.issue_stop    = out_item_q.issue_stop;
  assign out_o.transmit_mode = out_item_q.transmit_mode;
  assign out_o.address_out   = out_item_q.address_out;
  assign out_o.byte_valid    = out_item_q.byte_valid;
  assign out_o.msg_index     = out_item_q.msg_index;
  assign out_o.byte_offset   = out_item_q.byte_offset;
  assign out_o.store_byte    = out_item_q.store_byte;
  assign out_o.done_res      = out_item_q.done_res;

endmodule

// ----- hdl/i2cms_chk.sv -----
// port-level checker for the sequencer top level, with its bind
`include "i2c_multi_message_sequencer_core_assert.svh"

module i2cms_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_issue_start_i,
  input logic       out_issue_stop_i,
  input logic       out_byte_valid_i,
  input logic [2:0] out_msg_index_i,
  input logic [7:0] out_byte_offset_i,
  input logic [7:0] out_store_byte_i
);

  `I2CMS_ASSERT_MSG(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_issue_start_i) && $stable(out_issue_stop_i) && $stable(out_msg_index_i) && $stable(out_byte_offset_i) && $stable(out_store_byte_i), "result changed while stalled")
  `I2CMS_ASSERT(a_in_stall, !in_ready_i |-> out_valid_i && !out_ready_i)
  `I2CMS_ASSERT(a_result_due, in_valid_i && in_ready_i ##1 (!out_valid_i || out_ready_i) |=> out_valid_i)
  `I2CMS_ASSERT(a_no_byte_zero, out_valid_i && !out_byte_valid_i |-> out_msg_index_i == 3'd0 && out_byte_offset_i == 8'd0 && out_store_byte_i == 8'd0)

endmodule

bind i2c_multi_message_sequencer_core i2cms_chk u_i2cms_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_issue_start_i (out_o.issue_start),
  .out_issue_stop_i  (out_o.issue_stop),
  .out_byte_valid_i  (out_o.byte_valid),
  .out_msg_index_i   (out_o.msg_index),
  .out_byte_offset_i (out_o.byte_offset),
  .out_store_byte_i  (out_o.store_byte)
);

// ----- dv/i2cms_bus_cmd_check.sv -----
// bus command predictor and result comparison for the i2c multi-message sequencer
module i2cms_bus_cmd_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cms_in_if         in_ch,
  i2cms_out_if        out_ch,
  output int unsigned fail_count,
  output int unsigned pending_count,
  output int unsigned checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  i2cms_pkg::desc_t     desc_tbl [i2cms_pkg::MAX_MESSAGES_DEF];
  logic [2:0]           msgs_left;
  logic [2:0]           cur_msg;
  logic [7:0]           bytes_left;
  logic [7:0]           cur_off;
  logic                 tx_mode;
  logic [6:0]           addr;

  i2cms_pkg::out_item_t bus_cmd_q [$];

  task automatic report_fail(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_fail($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  function automatic logic single_read_left();
    return (msgs_left == 3'd0) && (bytes_left == 8'd1);
  endfunction

  function automatic void step_message();
    msgs_left  = msgs_left - 3'd1;
    cur_msg    = cur_msg + 3'd1;
    cur_off    = 8'd0;
    bytes_left = desc_tbl[cur_msg].length;
  endfunction

  function automatic i2cms_pkg::out_item_t next_bus_cmd(i2cms_pkg::in_item_t c);
    i2cms_pkg::out_item_t r;
    i2cms_pkg::desc_t     d;
    logic [3:0]           cnt;
    logic                 send;
    r = '0;
    case (c.func)
      i2cms_pkg::FUNC_LOAD: begin
        if (c.desc_index < i2cms_pkg::MAX_MESSAGES_DEF) begin
          desc_tbl[c.desc_index] = '{nors: c.desc_nors, rd: c.desc_read,
                                     length: c.desc_length};
        end
      end
      i2cms_pkg::FUNC_START: begin
        cnt = c.msg_count;
        if (cnt == 4'd0) cnt = 4'd1;
        if (cnt > i2cms_pkg::MAX_MESSAGES_DEF) cnt = 4'(i2cms_pkg::MAX_MESSAGES_DEF);
        addr       = c.slave_address;
        msgs_left  = 3'(cnt - 4'd1);
        cur_msg    = 3'd0;
        cur_off    = 8'd0;
        d          = desc_tbl[0];
        bytes_left = d.length;
        r.issue_start = 1'b1;
        if (d.rd) begin
          tx_mode      = 1'b0;
          r.issue_stop = single_read_left();
        end else begin
          tx_mode = 1'b1;
        end
      end
      i2cms_pkg::FUNC_TX_READY: begin
        send = 1'b1;
        if (bytes_left == 8'd0) begin
          if (msgs_left != 3'd0) begin
            step_message();
            d = desc_tbl[cur_msg];
            if (d.rd) begin
              tx_mode       = 1'b0;
              r.issue_start = 1'b1;
              r.issue_stop  = single_read_left();
              send          = 1'b0;
            end else if (!d.nors) begin
              r.issue_start = 1'b1;
              send          = 1'b0;
            end
          end else begin
            r.issue_stop = 1'b1;
            send         = 1'b0;
          end
        end
        if (send && bytes_left != 8'd0) begin
          r.byte_valid  = 1'b1;
          r.msg_index   = cur_msg;
          r.byte_offset = cur_off;
          cur_off       = cur_off + 8'd1;
          bytes_left    = bytes_left - 8'd1;
        end
      end
      default: begin
        if (bytes_left != 8'd0) bytes_left = bytes_left - 8'd1;
        r.byte_valid  = 1'b1;
        r.msg_index   = cur_msg;
        r.byte_offset = cur_off;
        r.store_byte  = c.rx_byte;
        cur_off       = cur_off + 8'd1;
        if (bytes_left == 8'd0) begin
          if (msgs_left != 3'd0) begin
            step_message();
            d = desc_tbl[cur_msg];
            if (d.rd) begin
              if (!d.nors) begin
                r.issue_start = 1'b1;
                r.issue_stop  = single_read_left();
              end
            end else begin
              tx_mode       = 1'b1;
              r.issue_start = 1'b1;
            end
          end
        end else if (single_read_left()) begin
          r.issue_stop = 1'b1;
        end
      end
    endcase
    r.transmit_mode = tx_mode;
    r.address_out   = addr;
    r.done_res      = (bytes_left == 8'd0) && (msgs_left == 3'd0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    i2cms_pkg::in_item_t  cmd;
    i2cms_pkg::out_item_t got;
    i2cms_pkg::out_item_t want;
    if (!rst_ni) begin
      msgs_left     = '0;
      cur_msg       = '0;
      bytes_left    = '0;
      cur_off       = '0;
      tx_mode       = 1'b0;
      addr          = '0;
      bus_cmd_q.delete();
      fail_count    = 0;
      checked_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{issue_start: out_ch.issue_start, issue_stop: out_ch.issue_stop,
                transmit_mode: out_ch.transmit_mode, address_out: out_ch.address_out,
                byte_valid: out_ch.byte_valid, msg_index: out_ch.msg_index,
                byte_offset: out_ch.byte_offset, store_byte: out_ch.store_byte,
                done_res: out_ch.done_res};
        if (bus_cmd_q.size() == 0) begin
          report_fail("result with no command outstanding");
        end else begin
          want = bus_cmd_q.pop_front();
          check_field("issue_start", got.issue_start, want.issue_start);
          check_field("issue_stop", got.issue_stop, want.issue_stop);
          check_field("transmit_mode", got.transmit_mode, want.transmit_mode);
          check_field("address_out", got.address_out, want.address_out);
          check_field("byte_valid", got.byte_valid, want.byte_valid);
          check_field("msg_index", got.msg_index, want.msg_index);
          check_field("byte_offset", got.byte_offset, want.byte_offset);
          check_field("store_byte", got.store_byte, want.store_byte);
          check_field("done_res", got.done_res, want.done_res);
          checked_count++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        cmd = '{func: i2cms_pkg::func_e'(in_ch.func), desc_index: in_ch.desc_index,
                desc_length: in_ch.desc_length, desc_read: in_ch.desc_read,
                desc_nors: in_ch.desc_nors, slave_address: in_ch.slave_address,
                msg_count: in_ch.msg_count, rx_byte: in_ch.rx_byte};
        bus_cmd_q.push_back(next_bus_cmd(cmd));
      end
    end
    pending_count = bus_cmd_q.size();
  end

endmodule

// ----- dv/tb_i2c_multi_message_sequencer_core.sv -----
// stimulus, flow control and verdict for the i2c multi-message sequencer
module tb_i2c_multi_message_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 1200;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 8;

  logic        clk_i;
  logic        rst_ni;
  int          cycle_count = 0;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned checked_count;

  int          sent_count;
  int          func_count [4];
  int          burst_left;
  bit          no_gaps;
  bit          held_off;
  int          shadow_len [i2cms_pkg::MAX_MESSAGES_DEF];
  bit          shadow_rd  [i2cms_pkg::MAX_MESSAGES_DEF];

  i2cms_in_if  in_if ();
  i2cms_out_if out_if ();

  i2c_multi_message_sequencer_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  i2cms_bus_cmd_check u_bus_cmd_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_if),
    .out_ch        (out_if),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
    $display("TEST FAILED");
    $finish;
  end

  function automatic i2cms_pkg::in_item_t rand_item();
    i2cms_pkg::in_item_t c;
    c.func          = i2cms_pkg::func_e'($urandom_range(0, 3));
    c.desc_index    = 3'($urandom_range(0, 7));
    c.desc_length   = 8'($urandom_range(0, 255));
    c.desc_read     = 1'($urandom_range(0, 1));
    c.desc_nors     = 1'($urandom_range(0, 1));
    c.slave_address = 7'($urandom_range(0, 127));
    c.msg_count     = 4'($urandom_range(0, 15));
    c.rx_byte       = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic i2cms_pkg::in_item_t cmd_load(int idx, int len, bit rd, bit nors);
    i2cms_pkg::in_item_t c;
    c             = rand_item();
    c.func        = i2cms_pkg::FUNC_LOAD;
    c.desc_index  = 3'(idx);
    c.desc_length = 8'(len);
    c.desc_read   = rd;
    c.desc_nors   = nors;
    return c;
  endfunction

  function automatic i2cms_pkg::in_item_t cmd_start(int address, int cnt);
    i2cms_pkg::in_item_t c;
    c               = rand_item();
    c.func          = i2cms_pkg::FUNC_START;
    c.slave_address = 7'(address);
    c.msg_count     = 4'(cnt);
    return c;
  endfunction

  function automatic i2cms_pkg::in_item_t cmd_tx();
    i2cms_pkg::in_item_t c;
    c      = rand_item();
    c.func = i2cms_pkg::FUNC_TX_READY;
    return c;
  endfunction

  function automatic i2cms_pkg::in_item_t cmd_rx(int data);
    i2cms_pkg::in_item_t c;
    c         = rand_item();
    c.func    = i2cms_pkg::FUNC_RX_BYTE;
    c.rx_byte = 8'(data);
    return c;
  endfunction

  task automatic drive_item(i2cms_pkg::in_item_t c);
    in_if.func          <= c.func;
    in_if.desc_index    <= c.desc_index;
    in_if.desc_length   <= c.desc_length;
    in_if.desc_read     <= c.desc_read;
    in_if.desc_nors     <= c.desc_nors;
    in_if.slave_address <= c.slave_address;
    in_if.msg_count     <= c.msg_count;
    in_if.rx_byte       <= c.rx_byte;
  endtask

  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      drive_item(rand_item());
    end
  endtask

  task automatic offer(i2cms_pkg::in_item_t c);
    if (burst_left == 0) begin
      if (!no_gaps) idle_for($urandom_range(1, 8));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    drive_item(c);
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    sent_count++;
    func_count[c.func]++;
    if (c.func == i2cms_pkg::FUNC_LOAD) begin
      shadow_len[c.desc_index] = c.desc_length;
      shadow_rd[c.desc_index]  = c.desc_read;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  // optionally load descriptors, start, then walk each message as a bus engine would, at times cut short
  task automatic run_transfer();
    int cnt;
    int eff;
    int m;
    int n;
    int len;
    bit full;
    cnt  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
    eff  = (cnt == 0) ? 1 : ((cnt > i2cms_pkg::MAX_MESSAGES_DEF) ?
                             i2cms_pkg::MAX_MESSAGES_DEF : cnt);
    full = ($urandom_range(0, 39) == 0);
    if ($urandom_range(0, 1) == 1) begin
      for (m = 0; m < eff; m++) begin
        len = $urandom_range(0, 19);
        len = (len < 14) ? $urandom_range(0, 3) :
              (len < 19) ? $urandom_range(4, 12) : $urandom_range(100, 255);
        offer(cmd_load(m, len, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0)));
      end
    end
    offer(cmd_start($urandom_range(0, 127), cnt));
    for (m = 0; m < eff; m++) begin
      if ($urandom_range(0, 24) == 0) break;
      n = shadow_len[m];
      if (n > 16 && !full) n = $urandom_range(1, 16);
      if (shadow_rd[m]) begin
        repeat ((n == 0) ? 1 : n) offer(cmd_rx($urandom_range(0, 255)));
      end else begin
        repeat (n + 1) offer(cmd_tx());
      end
    end
  endtask

  initial begin
    int mode;
    int seg;
    int k;
    int ph;
    out_if.ready = 1'b0;
    held_off     = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held_off && cycle_count >= HOLD_AT) begin
        held_off = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          out_if.ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(20, 200);
      k    = $urandom_range(2, 5);
      for (ph = 0; ph < seg; ph++) begin
        @(negedge clk_i);
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= ($urandom_range(0, 9) < 7);
          2:       out_if.ready <= ($urandom_range(0, 9) < 3);
          default: out_if.ready <= ((ph % k) != 0);
        endcase
      end
    end
  end

  initial begin
    bit drained;
    in_if.valid         = 1'b0;
    in_if.func          = i2cms_pkg::FUNC_LOAD;
    in_if.desc_index    = '0;
    in_if.desc_length   = '0;
    in_if.desc_read     = 1'b0;
    in_if.desc_nors     = 1'b0;
    in_if.slave_address = '0;
    in_if.msg_count     = '0;
    in_if.rx_byte       = '0;
    sent_count  = 0;
    burst_left  = 0;
    no_gaps     = 1'b0;
    drained     = 1'b0;
    func_count  = '{default: 0};
    rst_ni      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // nothing started yet: stop request and empty counter on receive
    offer(cmd_tx());
    offer(cmd_rx(8'h00));
    offer(cmd_load(0, 1, 1'b0, 1'b0));
    offer(cmd_load(1, 0, 1'b0, 1'b1));
    offer(cmd_load(2, 2, 1'b0, 1'b0));
    offer(cmd_load(3, 1, 1'b1, 1'b0));
    offer(cmd_load(4, 2, 1'b1, 1'b1));
    offer(cmd_load(5, 0, 1'b1, 1'b0));
    offer(cmd_load(6, 2, 1'b0, 1'b1));
    offer(cmd_load(7, 1, 1'b1, 1'b0));
    // zero message count, then an oversized one walking every slot
    offer(cmd_start(0, 0));
    offer(cmd_tx());
    offer(cmd_start(127, 15));
    repeat (6) offer(cmd_tx());
    repeat (4) offer(cmd_rx($urandom_range(0, 255)));
    offer(cmd_tx());
    // receive while transmitting, then single last read byte with stop
    offer(cmd_rx($urandom_range(0, 255)));
    offer(cmd_rx(8'hFF));
    offer(cmd_tx());

    // long read that runs past its length so the byte offset wraps
    offer(cmd_load(0, 255, 1'b1, 1'b0));
    offer(cmd_start($urandom_range(0, 127), 1));
    repeat (258) offer(cmd_rx($urandom_range(0, 255)));

    while (sent_count < ITEM_TARGET) begin
      if (!drained && sent_count >= ITEM_TARGET / 2) begin
        wait_drained();
        drained = 1'b1;
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) offer(rand_item());
      end else begin
        run_transfer();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    $display("covered %0d transactions: %0d loads, %0d starts, %0d transmit-ready, %0d received",
             sent_count, func_count[i2cms_pkg::FUNC_LOAD], func_count[i2cms_pkg::FUNC_START],
             func_count[i2cms_pkg::FUNC_TX_READY], func_count[i2cms_pkg::FUNC_RX_BYTE]);
    $display("%0d results compared, long receiver hold-off and mid-run drain included",
             checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/i2cms_pkg.sv
hdl/i2cms_if.sv
hdl/i2cms_desc_tbl.sv
hdl/i2cms_seq.sv
hdl/i2c_multi_message_sequencer_core.sv
hdl/i2cms_chk.sv
dv/i2cms_bus_cmd_check.sv
dv/tb_i2c_multi_message_sequencer_core.sv
